// ===== rtl/eac_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder acceleration package
// Shared types and constants for the encoder acceleration block.
// ----------------------------------------------------------------------------
package eac_pkg;

	localparam int IDX_W       = 2;
	localparam int DELTA_W     = 5;
	localparam int TIME_W      = 32;
	localparam int POS_W       = 16;
	localparam int CC_W        = 7;
	localparam int CN_W        = 3;
	localparam int CH_W        = 5;
	localparam int GAIN_W      = 8;
	localparam int CUT_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int DIVIDEND_W  = 24;
	localparam int DIVISOR_W   = 16;

	localparam logic [CC_W-1:0] CC_MAX = 7'd127;

	localparam logic [GAIN_W-1:0] GAIN_RST    = 8'd10;
	localparam logic [CUT_W-1:0]  SLOW_RST    = 16'd200;
	localparam logic [CUT_W-1:0]  FAST_RST    = 16'd5;
	localparam logic [CH_W-1:0]   CHANNEL_RST = 5'd1;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_GAIN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_CUTOFF  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_CUTOFF  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIDI_CHANNEL = 2'd3;

	typedef struct packed {
		logic [IDX_W-1:0]          encoder_index;
		logic signed [DELTA_W-1:0] step_delta;
		logic [TIME_W-1:0]         now_ms;
	} item_t;

	typedef struct packed {
		logic [GAIN_W-1:0] max_gain;
		logic [CUT_W-1:0]  slow_cutoff_ms;
		logic [CUT_W-1:0]  fast_cutoff_ms;
		logic [CH_W-1:0]   midi_channel;
	} cfg_t;

endpackage

// ===== rtl/encoder_acceleration_cc.sv =====
// ----------------------------------------------------------------------------
// Encoder acceleration controller
// Turns encoder steps into accelerated, clamped controller values.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries an encoder index, a signed
// step and a millisecond timestamp; a transfer happens when in_valid is high
// and in_stall is low. A two-entry queue sits behind the input, and steps for
// encoders at or above NUM_ENCODERS are dropped there.
// A queued step ends in S_LOAD when its new position equals the last
// reported value; otherwise it goes through S_MUL, S_DIV when acceleration
// applies, and S_FIN, where it produces one result transfer on
// (out_valid, out_stall), held in an output register.
// While the receiver stalls, the output register holds its result and the
// back end waits with the next result; the queue keeps taking input until
// it is full.
// The user writes registers on (cfg_valid, cfg_ready) only while the block is
// idle, which the block does not enforce; cfg_ready is always high. Reset
// clears all encoder state and loads the default gain, cutoffs and channel.
// ----------------------------------------------------------------------------
module encoder_acceleration_cc #(
	parameter int NUM_ENCODERS = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [eac_pkg::IDX_W-1:0]            encoder_index,
	input  logic signed [eac_pkg::DELTA_W-1:0]   step_delta,
	input  logic [eac_pkg::TIME_W-1:0]           now_ms,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [eac_pkg::CN_W-1:0]             controller_number,
	output logic [eac_pkg::CH_W-1:0]             channel,
	output logic [eac_pkg::CC_W-1:0]             cc_value,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [eac_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [eac_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import eac_pkg::*;

	cfg_t  cfg_q;
	item_t in_item;
	item_t q_item;
	logic  q_valid;
	logic  q_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_gain       <= GAIN_RST;
			cfg_q.slow_cutoff_ms <= SLOW_RST;
			cfg_q.fast_cutoff_ms <= FAST_RST;
			cfg_q.midi_channel   <= CHANNEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_GAIN:     cfg_q.max_gain       <= cfg_data[GAIN_W-1:0];
				REG_SLOW_CUTOFF:  cfg_q.slow_cutoff_ms <= cfg_data[CUT_W-1:0];
				REG_FAST_CUTOFF:  cfg_q.fast_cutoff_ms <= cfg_data[CUT_W-1:0];
				REG_MIDI_CHANNEL: cfg_q.midi_channel   <= cfg_data[CH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_item.encoder_index = encoder_index;
	assign in_item.step_delta    = step_delta;
	assign in_item.now_ms        = now_ms;

	eac_front #(
		.NUM_ENCODERS (NUM_ENCODERS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	eac_back #(
		.NUM_ENCODERS (NUM_ENCODERS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_valid           (q_valid),
		.q_ready           (q_ready),
		.q_item            (q_item),
		.cfg               (cfg_q),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.controller_number (controller_number),
		.channel           (channel),
		.cc_value          (cc_value)
	);

endmodule

// ===== rtl/eac_front.sv =====
// ----------------------------------------------------------------------------
// Encoder acceleration front end
// Accepts input transfers, drops those for absent encoders and queues the rest.
// ----------------------------------------------------------------------------
module eac_front #(
	parameter int NUM_ENCODERS = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  eac_pkg::item_t in_item,
	output logic          q_valid,
	input  logic          q_ready,
	output eac_pkg::item_t q_item
);
	import eac_pkg::*;

	localparam logic [6:0] NUM_LIM = 7'(NUM_ENCODERS);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall && ({5'd0, in_item.encoder_index} < NUM_LIM);
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/eac_div.sv =====
// ----------------------------------------------------------------------------
// Encoder acceleration divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eac_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [eac_pkg::DIVIDEND_W-1:0]    dividend,
	input  logic [eac_pkg::DIVISOR_W-1:0]     divisor,
	output logic                              done,
	output logic [eac_pkg::DIVIDEND_W-1:0]    quotient
);
	import eac_pkg::*;

	logic [DIVIDEND_W-1:0] num_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  div_q;
	logic [4:0]            cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    shifted;
	logic                  fits;
	logic [DIVISOR_W:0]    diff;

	assign shifted  = {rem_q, num_q[DIVIDEND_W-1]};
	assign fits     = (shifted >= {1'b0, div_q});
	assign diff     = shifted - {1'b0, div_q};
	assign done     = done_q;
	assign quotient = num_q;

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= 5'(DIVIDEND_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/eac_back.sv =====
// ----------------------------------------------------------------------------
// Encoder acceleration back end
// Updates encoder state, applies the time-based acceleration and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module eac_back #(
	parameter int NUM_ENCODERS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	output logic                        q_ready,
	input  eac_pkg::item_t              q_item,
	input  eac_pkg::cfg_t               cfg,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [eac_pkg::CN_W-1:0]    controller_number,
	output logic [eac_pkg::CH_W-1:0]    channel,
	output logic [eac_pkg::CC_W-1:0]    cc_value
);
	import eac_pkg::*;

	localparam int DEPTH = (NUM_ENCODERS < 4) ? NUM_ENCODERS : 4;
	localparam int SEL_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL, S_DIV, S_FIN} state_t;

	state_t                   state_q;
	item_t                    item_q;
	logic signed [POS_W-1:0]  position_q [DEPTH];
	logic [CC_W-1:0]          last_value_q [DEPTH];
	logic [TIME_W-1:0]        last_time_q [DEPTH];
	logic signed [POS_W-1:0]  pos_q;
	logic signed [POS_W:0]    diff_q;
	logic [DIVISOR_W-1:0]     divisor_q;
	logic                     accel_q;
	logic                     neg_q;
	logic                     out_valid_q;
	logic [CN_W-1:0]          cn_q;
	logic [CH_W-1:0]          ch_q;
	logic [CC_W-1:0]          cc_q;

	logic [SEL_W-1:0]         sel;
	logic signed [POS_W-1:0]  cur_pos;
	logic [CC_W-1:0]          cur_last;
	logic signed [POS_W:0]    sum17;
	logic signed [POS_W-1:0]  sat_pos;
	logic [TIME_W-1:0]        elapsed;
	logic [CUT_W-1:0]         floor_t;
	logic signed [25:0]       prod;
	logic [25:0]              prod_mag;
	logic                     div_start;
	logic                     div_done;
	logic [DIVIDEND_W-1:0]    quo;
	logic signed [25:0]       q_signed;
	logic signed [25:0]       new_pos;
	logic [CC_W-1:0]          report;
	logic                     out_free;
	logic                     fin_fire;

	assign sel      = item_q.encoder_index[SEL_W-1:0];
	assign cur_pos  = position_q[sel];
	assign cur_last = last_value_q[sel];
	assign q_ready  = (state_q == S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign fin_fire = (state_q == S_FIN) && out_free;

	always_comb begin
		sum17 = {cur_pos[POS_W-1], cur_pos} + {{(POS_W-DELTA_W+1){item_q.step_delta[DELTA_W-1]}},
			item_q.step_delta};
		if (sum17 > 17'sd32767) begin
			sat_pos = 16'sh7fff;
		end else if (sum17 < -17'sd32768) begin
			sat_pos = -16'sh8000;
		end else begin
			sat_pos = sum17[POS_W-1:0];
		end
		elapsed = item_q.now_ms - last_time_q[sel];
		floor_t = (elapsed[CUT_W-1:0] < cfg.fast_cutoff_ms) ? cfg.fast_cutoff_ms
			: elapsed[CUT_W-1:0];
		if (floor_t == '0) begin
			floor_t = 16'd1;
		end
	end

	always_comb begin
		prod     = diff_q * $signed({1'b0, cfg.max_gain});
		prod_mag = prod[25] ? 26'(-prod) : 26'(prod);
	end

	assign div_start = (state_q == S_MUL) && accel_q;

	eac_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_mag[DIVIDEND_W-1:0]),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		if (!accel_q) begin
			q_signed = '0;
		end else if (neg_q) begin
			q_signed = -$signed({2'b00, quo});
		end else begin
			q_signed = $signed({2'b00, quo});
		end
		new_pos = {{(26-POS_W){pos_q[POS_W-1]}}, pos_q} + q_signed;
		if (new_pos < 26'sd0) begin
			report = '0;
		end else if (new_pos > 26'sd127) begin
			report = CC_MAX;
		end else begin
			report = new_pos[CC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					item_q <= q_item;
				end
			end
			S_LOAD: begin
				pos_q     <= sat_pos;
				diff_q    <= {sat_pos[POS_W-1], sat_pos} - {10'd0, cur_last};
				accel_q   <= (elapsed < {16'd0, cfg.slow_cutoff_ms});
				divisor_q <= floor_t;
			end
			S_MUL: begin
				neg_q <= prod[25];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cn_q        <= '0;
			ch_q        <= '0;
			cc_q        <= '0;
			for (int i = 0; i < DEPTH; i++) begin
				position_q[i]   <= '0;
				last_value_q[i] <= '0;
				last_time_q[i]  <= '0;
			end
		end else begin
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					position_q[sel] <= sat_pos;
					if (sat_pos == $signed({9'd0, cur_last})) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= accel_q ? S_DIV : S_FIN;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						if (accel_q) begin
							position_q[sel] <= $signed({9'd0, report});
						end
						last_value_q[sel] <= report;
						last_time_q[sel]  <= item_q.now_ms;
						cn_q              <= {1'b0, item_q.encoder_index} + 3'd1;
						ch_q              <= cfg.midi_channel;
						cc_q              <= report;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign controller_number = cn_q;
	assign channel           = ch_q;
	assign cc_value          = cc_q;

endmodule
